FILE: sv/dba_pkg.sv
// Shared definitions for the draw-batch admission core.
// Holds command and reason codes, counter slots and default sizes.
// No dependencies; imported by draw_batch_admission_core, its checkers and its bench.
package dba_pkg;

    // Default batch capacity in indices and number of addressable buffer groups.
    localparam int unsigned MAX_INDICES_DEF = 65536;
    localparam int unsigned MAX_GROUPS      = 64;

    // Field widths fixed by the word format.
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned FOG_W    = 8;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned GRP_W    = 6;
    localparam int unsigned PASS_W   = 4;
    localparam int unsigned SEL_W    = 3;
    localparam int unsigned REASON_W = 3;
    localparam int unsigned DCNT_W   = 17;
    localparam int unsigned STAT_W   = 32;
    localparam int unsigned NSTAT    = 8;
    localparam int unsigned GBUILT_W = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_BUILT = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_OFFER = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [REASON_W-1:0] {
        RSN_OK       = 3'd0,
        RSN_DISABLED = 3'd1,
        RSN_NOTRES   = 3'd2,
        RSN_STYLE    = 3'd3,
        RSN_LIT      = 3'd4,
        RSN_FOG      = 3'd5,
        RSN_FULL     = 3'd6,
        RSN_SPLIT    = 3'd7
    } t_reason;

    // Statistics counter slots.
    localparam logic [SEL_W-1:0] STAT_DRAWS  = 3'd0;
    localparam logic [SEL_W-1:0] STAT_SURFS  = 3'd1;
    localparam logic [SEL_W-1:0] STAT_TRIS   = 3'd2;
    localparam logic [SEL_W-1:0] STAT_NOTRES = 3'd3;
    localparam logic [SEL_W-1:0] STAT_LIT    = 3'd4;
    localparam logic [SEL_W-1:0] STAT_SPLIT  = 3'd5;
    localparam logic [SEL_W-1:0] STAT_FULL   = 3'd6;
    localparam logic [SEL_W-1:0] STAT_STYLE  = 3'd7;

endpackage

FILE: sv/draw_batch_admission_core.sv
// The result word of a taken command word is registered and shows in the next cycle.
// Throughput: one command word per cycle; the result register frees itself in
// the same cycle it is taken, so input is stalled only while i_out_stall holds a result.
// Reset (synchronous, active low) empties the batch, clears all eight counters,
// disables batching, sets groups_built to zero and drops the result valid.
// Depends on dba_pkg.
module draw_batch_admission_core #(
    parameter int unsigned MAX_INDICES = dba_pkg::MAX_INDICES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [dba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Command channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dba_pkg::CMD_W-1:0]      i_command,
    input  logic                           i_resident,
    input  logic                           i_style_stale,
    input  logic                           i_surface_lit,
    input  logic [dba_pkg::FOG_W-1:0]      i_fog_num,
    input  logic [dba_pkg::CNT_W-1:0]      i_index_count,
    input  logic [dba_pkg::GRP_W-1:0]      i_group,
    input  logic [dba_pkg::PASS_W-1:0]     i_draw_passes,
    input  logic [dba_pkg::SEL_W-1:0]      i_stat_select,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_accepted,
    output logic [dba_pkg::REASON_W-1:0]   o_reason,
    output logic                           o_draw_valid,
    output logic [dba_pkg::DCNT_W-1:0]     o_draw_index_count,
    output logic [dba_pkg::GRP_W-1:0]      o_draw_group,
    output logic [dba_pkg::FOG_W-1:0]      o_draw_fog,
    output logic [dba_pkg::STAT_W-1:0]     o_stat_value
);
    import dba_pkg::*;

    // Batch index width, the width of a capacity sum, and the divide-by-three
    // reciprocal: floor(x * ceil(2^K / 3) / 2^K) is exact for x below 2^BW.
    localparam int unsigned BW    = $clog2(MAX_INDICES + 1);
    localparam int unsigned SUMW  = ((BW > CNT_W) ? BW : CNT_W) + 1;
    localparam int unsigned DIV_K = BW + 2;
    localparam int unsigned PRODW = BW + DIV_K;
    localparam logic [DIV_K-1:0] DIV3_MAGIC = DIV_K'(((1 << DIV_K) + 2) / 3);
    localparam logic [SUMW-1:0]  CAP        = SUMW'(MAX_INDICES);

    // Configuration registers.
    logic                r_enable;
    logic [GBUILT_W-1:0] r_groups_built;

    // Open batch state.
    logic [BW-1:0]    r_batch_idx,  n_batch_idx;
    logic [GRP_W-1:0] r_batch_grp,  n_batch_grp;
    logic             r_batch_gval, n_batch_gval;
    logic [FOG_W-1:0] r_batch_fog,  n_batch_fog;

    // Statistics counters, each updated at its own slot.
    logic [STAT_W-1:0] r_stat [NSTAT];
    logic [STAT_W-1:0] n_stat [NSTAT];

    // Result register.
    logic                r_out_valid;
    logic                r_accepted,   n_accepted;
    t_reason             r_reason,     n_reason;
    logic                r_draw_valid, n_draw_valid;
    logic [DCNT_W-1:0]   r_draw_cnt,   n_draw_cnt;
    logic [GRP_W-1:0]    r_draw_grp,   n_draw_grp;
    logic [FOG_W-1:0]    r_draw_fog,   n_draw_fog;
    logic [STAT_W-1:0]   r_stat_val,   n_stat_val;

    logic              take;
    t_cmd              cmd;
    logic [SUMW-1:0]   idx_sum;
    logic [SUMW-1:0]   batch_ext;
    logic [PRODW-1:0]  div_prod;
    logic [BW-1:0]     tris;
    logic              flush_ok;
    logic [8:0]        grp_ext;

    // A new word is taken whenever the result register is empty or being drained.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;
    assign cmd        = t_cmd'(i_command);

    // Capacity sum, triangle count of the open batch and flush validity.
    assign batch_ext = SUMW'(r_batch_idx);
    assign idx_sum   = batch_ext + SUMW'(i_index_count);
    assign div_prod  = PRODW'(r_batch_idx) * PRODW'(DIV3_MAGIC);
    assign tris      = div_prod[PRODW-1:DIV_K];
    assign grp_ext   = 9'(r_batch_grp);
    assign flush_ok  = (r_batch_idx != '0) && r_batch_gval
                       && (grp_ext < 9'(r_groups_built))
                       && (grp_ext < 9'(MAX_GROUPS));

    // Command decode: next batch state, counters and result word.
    always_comb begin
        n_batch_idx  = r_batch_idx;
        n_batch_grp  = r_batch_grp;
        n_batch_gval = r_batch_gval;
        n_batch_fog  = r_batch_fog;
        for (int k = 0; k < NSTAT; k++) begin
            n_stat[k] = r_stat[k];
        end
        n_accepted   = 1'b0;
        n_reason     = RSN_OK;
        n_draw_valid = 1'b0;
        n_draw_cnt   = '0;
        n_draw_grp   = '0;
        n_draw_fog   = '0;
        n_stat_val   = '0;

        unique case (cmd)
            CMD_OFFER: begin
                // Checks in priority order; the first failure decides.
                if (!r_enable) begin
                    n_reason = RSN_DISABLED;
                end else if (!i_resident) begin
                    n_reason = RSN_NOTRES;
                    n_stat[STAT_NOTRES] = r_stat[STAT_NOTRES] + 1'b1;
                end else if (i_style_stale) begin
                    n_reason = RSN_STYLE;
                    n_stat[STAT_STYLE] = r_stat[STAT_STYLE] + 1'b1;
                end else if (i_surface_lit) begin
                    n_reason = RSN_LIT;
                    n_stat[STAT_LIT] = r_stat[STAT_LIT] + 1'b1;
                end else if ((r_batch_idx != '0) && (i_fog_num != r_batch_fog)) begin
                    n_reason = RSN_FOG;
                end else begin
                    // An empty batch takes this surface's fog, whatever follows.
                    if (r_batch_idx == '0) begin
                        n_batch_fog = i_fog_num;
                    end
                    if (idx_sum > CAP) begin
                        n_reason = RSN_FULL;
                        n_stat[STAT_FULL] = r_stat[STAT_FULL] + 1'b1;
                    end else if (r_batch_gval && (r_batch_grp != i_group)) begin
                        n_reason = RSN_SPLIT;
                        n_stat[STAT_SPLIT] = r_stat[STAT_SPLIT] + 1'b1;
                    end else begin
                        n_accepted   = 1'b1;
                        n_batch_idx  = idx_sum[BW-1:0];
                        n_batch_grp  = i_group;
                        n_batch_gval = 1'b1;
                        n_stat[STAT_SURFS] = r_stat[STAT_SURFS] + 1'b1;
                    end
                end
            end
            CMD_FLUSH: begin
                if (flush_ok) begin
                    n_stat[STAT_TRIS]  = r_stat[STAT_TRIS] + STAT_W'(tris);
                    n_stat[STAT_DRAWS] = r_stat[STAT_DRAWS] + STAT_W'(i_draw_passes);
                    n_draw_valid = 1'b1;
                    n_draw_cnt   = batch_ext[DCNT_W-1:0];
                    n_draw_grp   = r_batch_grp;
                    n_draw_fog   = r_batch_fog;
                end
                // Every flush empties the batch.
                n_batch_idx  = '0;
                n_batch_grp  = '0;
                n_batch_gval = 1'b0;
                n_batch_fog  = '0;
            end
            CMD_READ: begin
                n_stat_val = r_stat[i_stat_select];
            end
            CMD_CLEAR: begin
                for (int k = 0; k < NSTAT; k++) begin
                    n_stat[k] = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_groups_built <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                CFG_GROUPS_BUILT: r_groups_built <= i_cfg_data[GBUILT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Batch state and counters advance on each taken word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_idx  <= '0;
            r_batch_grp  <= '0;
            r_batch_gval <= 1'b0;
            r_batch_fog  <= '0;
            for (int k = 0; k < NSTAT; k++) begin
                r_stat[k] <= '0;
            end
        end else if (take) begin
            r_batch_idx  <= n_batch_idx;
            r_batch_grp  <= n_batch_grp;
            r_batch_gval <= n_batch_gval;
            r_batch_fog  <= n_batch_fog;
            for (int k = 0; k < NSTAT; k++) begin
                r_stat[k] <= n_stat[k];
            end
        end
    end

    // Result valid: set by a new word, cleared once the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_accepted   <= n_accepted;
            r_reason     <= n_reason;
            r_draw_valid <= n_draw_valid;
            r_draw_cnt   <= n_draw_cnt;
            r_draw_grp   <= n_draw_grp;
            r_draw_fog   <= n_draw_fog;
            r_stat_val   <= n_stat_val;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_accepted;
    assign o_reason           = r_reason;
    assign o_draw_valid       = r_draw_valid;
    assign o_draw_index_count = r_draw_cnt;
    assign o_draw_group       = r_draw_grp;
    assign o_draw_fog         = r_draw_fog;
    assign o_stat_value       = r_stat_val;

endmodule

FILE: sv/dba_checker.sv
// Port-level checks for draw_batch_admission_core, attached by a bind.
// Depends on dba_pkg and the top-level port list.
module dba_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_accepted,
    input logic [dba_pkg::REASON_W-1:0]   o_reason,
    input logic                           o_draw_valid,
    input logic [dba_pkg::DCNT_W-1:0]     o_draw_index_count,
    input logic [dba_pkg::STAT_W-1:0]     o_stat_value
);
    import dba_pkg::*;

    // The input side is only held back by a result word that cannot leave.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result word");

    // Every taken word produces a result word in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word gave no result word");

    // An accepted surface carries the success code and no draw.
    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_reason == RSN_OK && !o_draw_valid))
        else $error("accepted surface with a reject code or a draw");

    // A stalled result word stays valid and keeps its stat value and draw index count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_stat_value) && $stable(o_draw_index_count)))
        else $error("stalled result word changed");

endmodule

bind draw_batch_admission_core dba_checker u_dba_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_accepted         (o_accepted),
    .o_reason           (o_reason),
    .o_draw_valid       (o_draw_valid),
    .o_draw_index_count (o_draw_index_count),
    .o_stat_value       (o_stat_value)
);

FILE: bench/draw_batch_admission_checker.sv
`timescale 1ns / 1ps
// Scoreboard for draw_batch_admission_core: keeps its own copy of the open batch,
// the counters and the registers, and predicts one result word per command word.
// Depends on dba_pkg; instantiated beside the core by draw_batch_admission_core_tb.
module draw_batch_admission_checker
    import dba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic                  i_resident,
    input  logic                  i_style_stale,
    input  logic                  i_surface_lit,
    input  logic [FOG_W-1:0]      i_fog_num,
    input  logic [CNT_W-1:0]      i_index_count,
    input  logic [GRP_W-1:0]      i_group,
    input  logic [PASS_W-1:0]     i_draw_passes,
    input  logic [SEL_W-1:0]      i_stat_select,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_accepted,
    input  logic [REASON_W-1:0]   i_reason,
    input  logic                  i_draw_valid,
    input  logic [DCNT_W-1:0]     i_draw_index_count,
    input  logic [GRP_W-1:0]      i_draw_group,
    input  logic [FOG_W-1:0]      i_draw_fog,
    input  logic [STAT_W-1:0]     i_stat_value,
    output int                    o_fail_count,
    output int                    o_owed
);

    typedef struct {
        logic              accepted;
        t_reason           reason;
        logic              draw_valid;
        logic [DCNT_W-1:0] draw_count;
        logic [GRP_W-1:0]  draw_group;
        logic [FOG_W-1:0]  draw_fog;
        logic [STAT_W-1:0] stat_value;
    } t_outcome;

    // Mirrored registers, batch state and statistics counters.
    logic                enabled;
    logic [GBUILT_W-1:0] groups_built;
    logic [DCNT_W-1:0]   batch_count;
    logic [GRP_W-1:0]    batch_group;
    logic                batch_has_group;
    logic [FOG_W-1:0]    batch_fog;
    logic [STAT_W-1:0]   stats [NSTAT];

    t_outcome owed_results [$];
    int       fail_tally;

    assign o_fail_count = fail_tally;

    function automatic void empty_batch();
        batch_count     = '0;
        batch_group     = '0;
        batch_has_group = 1'b0;
        batch_fog       = '0;
    endfunction

    // Applies one command word to the mirrored state and returns its result word.
    function automatic t_outcome admit_word(
        input t_cmd              cmd,
        input logic              resident,
        input logic              style_stale,
        input logic              surface_lit,
        input logic [FOG_W-1:0]  fog,
        input logic [CNT_W-1:0]  count,
        input logic [GRP_W-1:0]  grp,
        input logic [PASS_W-1:0] passes,
        input logic [SEL_W-1:0]  sel
    );
        t_outcome res;
        logic     fog_ok;
        longint   total;
        res.accepted   = 1'b0;
        res.reason     = RSN_OK;
        res.draw_valid = 1'b0;
        res.draw_count = '0;
        res.draw_group = '0;
        res.draw_fog   = '0;
        res.stat_value = '0;
        case (cmd)
            CMD_OFFER: begin
                // Checks run in priority order; the first failure decides the reason.
                if (!enabled) begin
                    res.reason = RSN_DISABLED;
                end else if (!resident) begin
                    stats[STAT_NOTRES] = stats[STAT_NOTRES] + 1;
                    res.reason = RSN_NOTRES;
                end else if (style_stale) begin
                    stats[STAT_STYLE] = stats[STAT_STYLE] + 1;
                    res.reason = RSN_STYLE;
                end else if (surface_lit) begin
                    stats[STAT_LIT] = stats[STAT_LIT] + 1;
                    res.reason = RSN_LIT;
                end else begin
                    // An empty batch takes the fog of the offer, even if it is rejected later.
                    fog_ok = 1'b1;
                    if (batch_count == 0) begin
                        batch_fog = fog;
                    end else if (fog != batch_fog) begin
                        fog_ok = 1'b0;
                    end
                    total = batch_count + count;
                    if (!fog_ok) begin
                        res.reason = RSN_FOG;
                    end else if (total > longint'(MAX_INDICES_DEF)) begin
                        stats[STAT_FULL] = stats[STAT_FULL] + 1;
                        res.reason = RSN_FULL;
                    end else if (batch_has_group && batch_group != grp) begin
                        stats[STAT_SPLIT] = stats[STAT_SPLIT] + 1;
                        res.reason = RSN_SPLIT;
                    end else begin
                        batch_group     = grp;
                        batch_has_group = 1'b1;
                        batch_count     = batch_count + count;
                        stats[STAT_SURFS] = stats[STAT_SURFS] + 1;
                        res.accepted = 1'b1;
                    end
                end
            end
            CMD_FLUSH: begin
                // A draw goes out only for a non-empty batch on a built group.
                if (batch_count != 0 && batch_has_group && batch_group < groups_built &&
                    batch_group < MAX_GROUPS) begin
                    stats[STAT_TRIS]  = stats[STAT_TRIS] + batch_count / 3;
                    stats[STAT_DRAWS] = stats[STAT_DRAWS] + passes;
                    res.draw_valid = 1'b1;
                    res.draw_count = batch_count;
                    res.draw_group = batch_group;
                    res.draw_fog   = batch_fog;
                end
                empty_batch();
            end
            CMD_READ: begin
                res.stat_value = stats[sel];
            end
            default: begin
                foreach (stats[k]) stats[k] = '0;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [STAT_W-1:0] want_v,
                               input logic [STAT_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v,
                     got_v);
            fail_tally++;
        end
    endtask

    // Results are matched before new words are queued: a word's result never
    // leaves at the edge where the word itself is taken.
    always @(posedge i_clk) begin : track
        t_outcome want;
        if (!i_rst_n) begin
            enabled      = 1'b0;
            groups_built = '0;
            empty_batch();
            foreach (stats[k]) stats[k] = '0;
            owed_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE:       enabled = i_cfg_data[0];
                    CFG_GROUPS_BUILT: groups_built = i_cfg_data[GBUILT_W-1:0];
                    default:          ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result word with nothing owed, expected none, actual reason %0d",
                             $time, i_reason);
                    fail_tally++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("accepted", want.accepted, i_accepted);
                    check_field("reason", want.reason, i_reason);
                    check_field("draw_valid", want.draw_valid, i_draw_valid);
                    check_field("draw_index_count", want.draw_count, i_draw_index_count);
                    check_field("draw_group", want.draw_group, i_draw_group);
                    check_field("draw_fog", want.draw_fog, i_draw_fog);
                    check_field("stat_value", want.stat_value, i_stat_value);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(admit_word(t_cmd'(i_command), i_resident,
                    i_style_stale, i_surface_lit, i_fog_num, i_index_count, i_group,
                    i_draw_passes, i_stat_select));
            end
        end
        o_owed <= owed_results.size();
    end

endmodule

FILE: bench/draw_batch_admission_core_tb.sv
`timescale 1ns / 1ps
// Top of the draw_batch_admission_core bench: clock, reset, command words,
// result stalls, a watchdog and the verdict.
// Depends on dba_pkg, draw_batch_admission_core and draw_batch_admission_checker.
module draw_batch_admission_core_tb;
    import dba_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 650;
    localparam int NPHASE       = 6;

    typedef struct {
        t_cmd              cmd;
        logic              resident;
        logic              style_stale;
        logic              surface_lit;
        logic [FOG_W-1:0]  fog;
        logic [CNT_W-1:0]  count;
        logic [GRP_W-1:0]  grp;
        logic [PASS_W-1:0] passes;
        logic [SEL_W-1:0]  sel;
    } t_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_command;
    logic                  i_resident;
    logic                  i_style_stale;
    logic                  i_surface_lit;
    logic [FOG_W-1:0]      i_fog_num;
    logic [CNT_W-1:0]      i_index_count;
    logic [GRP_W-1:0]      i_group;
    logic [PASS_W-1:0]     i_draw_passes;
    logic [SEL_W-1:0]      i_stat_select;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_accepted;
    logic [REASON_W-1:0]   o_reason;
    logic                  o_draw_valid;
    logic [DCNT_W-1:0]     o_draw_index_count;
    logic [GRP_W-1:0]      o_draw_group;
    logic [FOG_W-1:0]      o_draw_fog;
    logic [STAT_W-1:0]     o_stat_value;

    int fail_count;
    int owed;
    int burst_left;
    int quiet_cycles;
    int stall_mode;
    int stall_left;

    // Fog and group that well-formed offers keep to, so that batches grow.
    logic [FOG_W-1:0] cur_fog;
    logic [GRP_W-1:0] cur_grp;

    draw_batch_admission_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_resident         (i_resident),
        .i_style_stale      (i_style_stale),
        .i_surface_lit      (i_surface_lit),
        .i_fog_num          (i_fog_num),
        .i_index_count      (i_index_count),
        .i_group            (i_group),
        .i_draw_passes      (i_draw_passes),
        .i_stat_select      (i_stat_select),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_reason           (o_reason),
        .o_draw_valid       (o_draw_valid),
        .o_draw_index_count (o_draw_index_count),
        .o_draw_group       (o_draw_group),
        .o_draw_fog         (o_draw_fog),
        .o_stat_value       (o_stat_value)
    );

    draw_batch_admission_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_resident         (i_resident),
        .i_style_stale      (i_style_stale),
        .i_surface_lit      (i_surface_lit),
        .i_fog_num          (i_fog_num),
        .i_index_count      (i_index_count),
        .i_group            (i_group),
        .i_draw_passes      (i_draw_passes),
        .i_stat_select      (i_stat_select),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_accepted         (o_accepted),
        .i_reason           (o_reason),
        .i_draw_valid       (o_draw_valid),
        .i_draw_index_count (o_draw_index_count),
        .i_draw_group       (o_draw_group),
        .i_draw_fog         (o_draw_fog),
        .i_stat_value       (o_stat_value),
        .o_fail_count       (fail_count),
        .o_owed             (owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls on a pattern that is picked anew at random:
    // never, rarely, mostly, or one cycle in four.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_left % 4 == 0);
        endcase
    end

    // Ends the run when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A word with every field random; callers override the fields that matter.
    function automatic t_word noise_word(input t_cmd cmd);
        t_word w;
        w.cmd         = cmd;
        w.resident    = 1'($urandom_range(0, 1));
        w.style_stale = 1'($urandom_range(0, 1));
        w.surface_lit = 1'($urandom_range(0, 1));
        w.fog         = FOG_W'($urandom_range(0, 255));
        w.count       = CNT_W'($urandom_range(0, 65535));
        w.grp         = GRP_W'($urandom_range(0, 63));
        w.passes      = PASS_W'($urandom_range(0, 15));
        w.sel         = SEL_W'($urandom_range(0, 7));
        return w;
    endfunction

    // Sends one word, in bursts of random length separated by random gaps.
    task automatic send_word(input t_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_command     <= w.cmd;
        i_resident    <= w.resident;
        i_style_stale <= w.style_stale;
        i_surface_lit <= w.surface_lit;
        i_fog_num     <= w.fog;
        i_index_count <= w.count;
        i_group       <= w.grp;
        i_draw_passes <= w.passes;
        i_stat_select <= w.sel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic offer_surface(input logic res, input logic stale, input logic lit,
                                 input logic [FOG_W-1:0] fog, input logic [CNT_W-1:0] cnt,
                                 input logic [GRP_W-1:0] grp);
        t_word w;
        w             = noise_word(CMD_OFFER);
        w.resident    = res;
        w.style_stale = stale;
        w.surface_lit = lit;
        w.fog         = fog;
        w.count       = cnt;
        w.grp         = grp;
        send_word(w);
    endtask

    task automatic flush_batch(input logic [PASS_W-1:0] passes);
        t_word w;
        w        = noise_word(CMD_FLUSH);
        w.passes = passes;
        send_word(w);
    endtask

    task automatic read_stat(input logic [SEL_W-1:0] sel);
        t_word w;
        w     = noise_word(CMD_READ);
        w.sel = sel;
        send_word(w);
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes both registers while the core is idle.
    task automatic set_mode(input logic en, input logic [GBUILT_W-1:0] built);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= {(CFG_DATA_W-1)'($urandom_range(0, 63)), en};
        @(posedge i_clk);
        i_cfg_index <= CFG_GROUPS_BUILT;
        i_cfg_data  <= CFG_DATA_W'(built);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random word, mostly well-formed offers that build real batches.
    task automatic random_word();
        int pick;
        int sz;
        logic [CNT_W-1:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            sz = $urandom_range(0, 19);
            if (sz == 0) begin
                cnt = '0;
            end else if (sz == 1) begin
                cnt = '1;
            end else if (sz == 2) begin
                cnt = CNT_W'($urandom_range(20000, 65535));
            end else begin
                cnt = CNT_W'($urandom_range(1, 900));
            end
            if ($urandom_range(0, 9) == 0) begin
                send_word(noise_word(CMD_OFFER));
            end else begin
                offer_surface($urandom_range(0, 19) != 0, $urandom_range(0, 19) == 0,
                              $urandom_range(0, 19) == 0,
                              ($urandom_range(0, 9) == 0) ? FOG_W'($urandom) : cur_fog, cnt,
                              ($urandom_range(0, 9) == 0) ? GRP_W'($urandom) : cur_grp);
            end
        end else if (pick < 80) begin
            flush_batch(PASS_W'($urandom_range(0, 15)));
            cur_fog = ($urandom_range(0, 2) == 0) ? '0 : FOG_W'($urandom_range(0, 255));
            cur_grp = ($urandom_range(0, 1) == 0) ? GRP_W'($urandom_range(0, 7))
                                                 : GRP_W'($urandom_range(0, 63));
        end else if (pick < 97) begin
            read_stat(SEL_W'($urandom_range(0, 7)));
        end else begin
            send_word(noise_word(CMD_CLEAR));
        end
    endtask

    initial begin : stimulus
        logic [GBUILT_W-1:0] built_list [NPHASE];
        logic                en_list [NPHASE];
        int                  per_phase;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_OFFER;
        i_resident    <= 1'b0;
        i_style_stale <= 1'b0;
        i_surface_lit <= 1'b0;
        i_fog_num     <= '0;
        i_index_count <= '0;
        i_group       <= '0;
        i_draw_passes <= '0;
        i_stat_select <= '0;
        burst_left = 0;
        cur_fog    = '0;
        cur_grp    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Straight out of reset batching is off, and a flush of nothing draws nothing.
        offer_surface(1'b1, 1'b0, 1'b0, 8'h12, 16'd30, 6'd2);
        flush_batch(4'd3);

        // Each rejection in priority order, then a batch filled to capacity.
        set_mode(1'b1, 7'd64);
        offer_surface(1'b0, 1'b1, 1'b1, 8'h40, 16'd5, 6'd1);
        offer_surface(1'b1, 1'b1, 1'b1, 8'h40, 16'd5, 6'd1);
        offer_surface(1'b1, 1'b0, 1'b1, 8'h40, 16'd5, 6'd1);
        offer_surface(1'b1, 1'b0, 1'b0, 8'hFF, 16'hFFFF, 6'd63);
        offer_surface(1'b1, 1'b0, 1'b0, 8'h00, 16'd1, 6'd63);
        offer_surface(1'b1, 1'b0, 1'b0, 8'hFF, 16'd2, 6'd63);
        offer_surface(1'b1, 1'b0, 1'b0, 8'hFF, 16'd1, 6'd0);
        offer_surface(1'b1, 1'b0, 1'b0, 8'hFF, 16'd1, 6'd63);
        flush_batch(4'hF);

        // A zero-index surface latches its group but leaves the fog open.
        offer_surface(1'b1, 1'b0, 1'b0, 8'h07, 16'd0, 6'd5);
        offer_surface(1'b1, 1'b0, 1'b0, 8'h09, 16'd3, 6'd5);
        flush_batch(4'd0);
        flush_batch(4'd9);

        for (int s = 0; s < NSTAT; s++) read_stat(SEL_W'(s));
        send_word(noise_word(CMD_CLEAR));
        read_stat(STAT_TRIS);

        // A group at the built limit is not drawn.
        set_mode(1'b1, 7'd5);
        offer_surface(1'b1, 1'b0, 1'b0, 8'h00, 16'd6, 6'd5);
        flush_batch(4'd2);

        // Random phases over several register settings, extremes included.
        en_list    = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        built_list = '{7'd64, 7'd127, 7'd9, 7'd64, 7'd1, 7'd0};
        per_phase  = RANDOM_ITEMS / NPHASE;
        for (int p = 0; p < NPHASE; p++) begin
            set_mode(en_list[p], built_list[p]);
            for (int n = 0; n < per_phase; n++) begin
                if (n == per_phase / 2) wait_drained();
                random_word();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && owed == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
